### rtl/uqpd_pkg.sv
// ---------------------------------------------------------------------------
// uqpd_pkg
// Shared types, codes and helpers for the URL query parameter decoder.
// ---------------------------------------------------------------------------
package uqpd_pkg;

    // result kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_NAME_LIMIT  = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;

    // special bytes of a query string
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] LIMIT_RESET = 8'd31;

    // result queue depth default (at least two, one item pushes up to two)
    localparam int RES_DEPTH_DEF = 4;

    // one result beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
        logic       done;
    } res_t;

    // results of one decoded item, packed from slot 0
    typedef struct packed {
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } push_t;

    // hex digit value; anything that is not a hex digit counts as 0
    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

### rtl/uqpd_parse.sv
// ---------------------------------------------------------------------------
// uqpd_parse
// Input register, limit registers and the per-byte decode: splits names and
// values, percent-decodes, applies length limits and forms up to two results.
// ---------------------------------------------------------------------------
module uqpd_parse
    import uqpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input beat
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_has,
    input  logic        in_end,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // result side
    input  logic        room,
    output push_t       push
);

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       end_reg;

    logic [7:0] name_limit_reg;
    logic [7:0] value_limit_reg;

    logic       in_value_reg,  in_value_next;
    logic [1:0] esc_reg,       esc_next;
    logic [3:0] high_reg,      high_next;
    logic [7:0] ncount_reg,    ncount_next;
    logic [7:0] vcount_reg,    vcount_next;

    logic       adv;
    logic       ch_hit;
    logic       keep;
    logic       amp;
    logic [7:0] ch;
    logic       a_valid;
    res_t       res_a;
    res_t       res_b;

    assign adv      = in_valid_reg && room;
    assign in_ready = !in_valid_reg || adv;

    // hold the accepted beat until the queue can take its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            has_reg  <= in_has;
            end_reg  <= in_end;
        end
    end

    // write the length limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg  <= LIMIT_RESET;
            value_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NAME_LIMIT:  name_limit_reg  <= cfg_wdata;
                REG_VALUE_LIMIT: value_limit_reg <= cfg_wdata;
                default:         name_limit_reg  <= name_limit_reg;
            endcase
        end
    end

    // decode one byte, then close the request if it ends here
    always_comb
    begin
        in_value_next = in_value_reg;
        esc_next      = esc_reg;
        high_next     = high_reg;
        ncount_next   = ncount_reg;
        vcount_next   = vcount_reg;
        ch_hit        = 1'b0;
        amp           = 1'b0;
        ch            = byte_reg;
        keep          = 1'b0;

        if (has_reg)
        begin
            case (esc_reg)
                ESC_HIGH:
                begin
                    high_next = hex_digit(byte_reg);
                    esc_next  = ESC_LOW;
                end
                ESC_LOW:
                begin
                    ch       = {high_reg, hex_digit(byte_reg)};
                    esc_next = ESC_NONE;
                    ch_hit   = 1'b1;
                end
                default:
                begin
                    if (byte_reg == CH_PERCENT)
                    begin
                        esc_next = ESC_HIGH;
                    end
                    else if (byte_reg == CH_AMP)
                    begin
                        amp           = 1'b1;
                        in_value_next = 1'b0;
                        esc_next      = ESC_NONE;
                        high_next     = 4'h0;
                        ncount_next   = 8'd0;
                        vcount_next   = 8'd0;
                    end
                    else if (byte_reg == CH_EQUAL && !in_value_reg)
                    begin
                        in_value_next = 1'b1;
                    end
                    else if (byte_reg == CH_PLUS)
                    begin
                        ch     = CH_SPACE;
                        ch_hit = 1'b1;
                    end
                    else
                    begin
                        ch_hit = 1'b1;
                    end
                end
            endcase
        end

        // count a kept character against its part's limit
        if (ch_hit)
        begin
            if (in_value_reg)
            begin
                keep = vcount_reg < value_limit_reg;
                if (keep)
                begin
                    vcount_next = vcount_reg + 8'd1;
                end
            end
            else
            begin
                keep = ncount_reg < name_limit_reg;
                if (keep)
                begin
                    ncount_next = ncount_reg + 8'd1;
                end
            end
        end

        // request end drops any pending escape and clears the parameter
        if (end_reg)
        begin
            in_value_next = 1'b0;
            esc_next      = ESC_NONE;
            high_next     = 4'h0;
            ncount_next   = 8'd0;
            vcount_next   = 8'd0;
        end
    end

    // form the results: byte result first, closing result second
    always_comb
    begin
        a_valid = (ch_hit && keep) || amp;

        res_a.kind = amp ? KIND_END : (in_value_reg ? KIND_VALUE : KIND_NAME);
        res_a.ch   = amp ? 8'h00 : ch;
        res_a.last = !end_reg;
        res_a.done = 1'b0;

        res_b.kind = KIND_END;
        res_b.ch   = 8'h00;
        res_b.last = 1'b1;
        res_b.done = 1'b1;

        push.res0 = a_valid ? res_a : res_b;
        push.res1 = res_b;
        if (!adv)
        begin
            push.cnt = 2'd0;
        end
        else
        begin
            push.cnt = {1'b0, a_valid} + {1'b0, end_reg};
        end
    end

    // advance the parameter state when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            high_reg     <= 4'h0;
            ncount_reg   <= 8'd0;
            vcount_reg   <= 8'd0;
        end
        else if (adv)
        begin
            in_value_reg <= in_value_next;
            esc_reg      <= esc_next;
            high_reg     <= high_next;
            ncount_reg   <= ncount_next;
            vcount_reg   <= vcount_next;
        end
    end

`ifndef ASSERT_OFF
    a_esc_code: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg != 2'd3)
        else $error("escape step holds an unused code");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && end_reg) |=> (esc_reg == ESC_NONE && !in_value_reg &&
                              ncount_reg == 8'd0 && vcount_reg == 8'd0))
        else $error("request end did not clear the parameter state");

    a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.res1.kind == KIND_END && push.res1.done &&
                                !push.res0.last))
        else $error("second result of an item is not the closing result");
`endif

endmodule

### rtl/uqpd_res_fifo.sv
// ---------------------------------------------------------------------------
// uqpd_res_fifo
// Result queue: takes up to two results per cycle, sends one beat per cycle while m_tready is high.
// ---------------------------------------------------------------------------
module uqpd_res_fifo
    import uqpd_pkg::*;
#(
    parameter int DEPTH = RES_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // decoded_char
    output logic [2:0] m_tuser,   // [1:0] kind, [2] request_done
    output logic       m_tlast    // run_last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] wr_ptr_inc;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    res_t          head;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop        = m_tvalid && m_tready;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    // room for two results once this cycle's beat is gone
    assign room = {1'b0, count_reg} <= ((CW+1)'(DEPTH - 2) + {{CW{1'b0}}, pop});

    // store the pushed results
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.res1;
        end
    end

    always_comb
    begin
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CW'(push.cnt) - CW'(pop);
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    // drive the head entry
    assign head     = mem_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = head.ch;
    assign m_tuser  = {head.done, head.kind};
    assign m_tlast  = head.last;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> room)
        else $error("results pushed without room");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.cnt == 2'd0 && count_reg == CW'(1)) |=> !m_tvalid)
        else $error("queue did not empty after its last beat left");
`endif

endmodule

### rtl/url_query_param_decoder.sv
// ---------------------------------------------------------------------------
// url_query_param_decoder
// Streaming URL query string decoder: names, values and parameter ends.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one raw query byte per beat in s_tdata, s_tuser set
//   when the byte is valid (clear for an empty closing beat), s_tlast set on
//   the beat after which the request ends.
//   Master channel m_*: one result per beat; m_tuser carries the kind (name
//   char, value char, end of parameter) and the request-done flag, m_tdata
//   the decoded character, m_tlast marks the last result of an input beat.
//   Config port: cfg_we with cfg_addr 0 writes the name limit, 1 the value
//   limit; write only while the block is idle.
// Path: an accepted beat waits in the input register until the queue has
//   room; its results are registered in the queue, which feeds m_*.
// Throughput: one input beat per cycle while the queue has room; the master
//   side moves one result per cycle, so the two results of one beat (a byte
//   plus the request end) leave in turn through the queue's single read port.
// Reset: parameter state clears and both limits return to 31.
// Stall: results wait in a small queue; when it cannot take two more, the
//   input register holds its beat and s_tready drops.
// ---------------------------------------------------------------------------
module url_query_param_decoder
    import uqpd_pkg::*;
#(
    parameter int RES_DEPTH = RES_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // byte_in
    input  logic       s_tuser,   // has_byte
    input  logic       s_tlast,   // request_end
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // decoded_char
    output logic [2:0] m_tuser,   // [1:0] kind, [2] request_done
    output logic       m_tlast,   // run_last
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata
);

    push_t push;
    logic  room;

    // decode stage
    uqpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_has    (s_tuser),
        .in_end    (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .room      (room),
        .push      (push)
    );

    // result queue
    uqpd_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/url_query_param_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// url_query_param_decoder_test
// Self-checking bench for the streaming URL query decoder. Query bytes are
// fed on the input stream while a local decoder model computes the name,
// value and end-of-parameter beats that each byte must produce. Every result
// beat is checked field by field against the oldest expected one. Directed
// strings cover escapes, '+', separators and request closings. Random query
// strings then run under several name and value limits, with random gaps on
// the input side and random stalls on the result side.
// ---------------------------------------------------------------------------
module url_query_param_decoder_test;
    import uqpd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_phase_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       cfg_we    = 1'b0;
    logic       cfg_addr  = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    // decoder model state and its copy of the limits
    logic [7:0] lim_name   = LIMIT_RESET;
    logic [7:0] lim_value  = LIMIT_RESET;
    logic       in_value_part = 1'b0;
    esc_phase_t esc_phase  = ESC_NONE;
    logic [3:0] esc_high   = 4'h0;
    logic [7:0] name_kept  = 8'h00;
    logic [7:0] value_kept = 8'h00;

    res_t beat_results[$];
    res_t pending_results[$];

    bit feed_idle = 1'b1;
    bit sink_idle = 1'b1;
    int fed_items    = 0;
    int seen_results = 0;
    int limit_writes = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    url_query_param_decoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // byte_in
        .s_tuser   (s_tuser),    // has_byte
        .s_tlast   (s_tlast),    // request_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // decoded_char
        .m_tuser   (m_tuser),    // [1:0] kind, [2] request_done
        .m_tlast   (m_tlast),    // run_last
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------------

    // value of a hex digit; anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        return d[3:0];
    endfunction

    task automatic clear_param();
        in_value_part = 1'b0;
        esc_phase     = ESC_NONE;
        esc_high      = 4'h0;
        name_kept     = 8'h00;
        value_kept    = 8'h00;
    endtask

    // keep a decoded character unless its part is already full
    task automatic keep_char(input logic [7:0] c);
        res_t r;
        r.ch   = c;
        r.last = 1'b0;
        r.done = 1'b0;
        if (in_value_part)
        begin
            if (value_kept < lim_value)
            begin
                value_kept++;
                r.kind = KIND_VALUE;
                beat_results.push_back(r);
            end
        end
        else if (name_kept < lim_name)
        begin
            name_kept++;
            r.kind = KIND_NAME;
            beat_results.push_back(r);
        end
    endtask

    task automatic close_param(input logic fin);
        res_t r;
        r.kind = KIND_END;
        r.ch   = 8'h00;
        r.last = 1'b0;
        r.done = fin;
        beat_results.push_back(r);
        clear_param();
    endtask

    // decode one accepted beat and queue the results it must produce
    task automatic predict_beat(input logic [7:0] b, input logic has, input logic fin);
        beat_results.delete();
        if (has)
        begin
            if (esc_phase == ESC_HIGH)
            begin
                esc_high  = hex_value(b);
                esc_phase = ESC_LOW;
            end
            else if (esc_phase == ESC_LOW)
            begin
                esc_phase = ESC_NONE;
                keep_char({esc_high, hex_value(b)});
            end
            else if (b == CH_PERCENT)
                esc_phase = ESC_HIGH;
            else if (b == CH_AMP)
                close_param(1'b0);
            else if (b == CH_EQUAL && !in_value_part)
                in_value_part = 1'b1;
            else if (b == CH_PLUS)
                keep_char(CH_SPACE);
            else
                keep_char(b);
        end
        if (fin)
            close_param(1'b1);
        if (beat_results.size() > 0)
            beat_results[beat_results.size() - 1].last = 1'b1;
        foreach (beat_results[i])
            pending_results.push_back(beat_results[i]);
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // present one beat, after a random gap if feed_idle is set, and hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic has, input logic fin);
        int gap;
        gap = feed_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(b, has, fin);
        if (has || fin)
            fed_items++;
    endtask

    // send a string byte by byte, optionally ending the request on its last byte
    task automatic send_text(input string txt, input bit end_on_last);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_beat(txt[i], 1'b1, end_on_last && (i == txt.len() - 1));
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NAME_LIMIT)
            lim_name = val;
        else
            lim_value = val;
        limit_writes++;
    endtask

    task automatic set_limits(input logic [7:0] nl, input logic [7:0] vl);
        wait_drained();
        write_limit(REG_NAME_LIMIT, nl);
        write_limit(REG_VALUE_LIMIT, vl);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
    endfunction

    // one character of a parameter: mostly plain, some '+', '=', escapes and junk
    task automatic send_query_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
        begin
            case ($urandom_range(0, 2))
                0: send_beat(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
                1: send_beat(8'("A" + $urandom_range(0, 25)), 1'b1, 1'b0);
                default: send_beat(8'("a" + $urandom_range(0, 25)), 1'b1, 1'b0);
            endcase
        end
        else if (pick < 14)
            send_beat(CH_PLUS, 1'b1, 1'b0);
        else if (pick < 17)
        begin
            send_beat(CH_PERCENT, 1'b1, 1'b0);
            send_beat(rand_hex_char(), 1'b1, 1'b0);
            send_beat(rand_hex_char(), 1'b1, 1'b0);
        end
        else if (pick == 17)
        begin
            send_beat(CH_PERCENT, 1'b1, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        else if (pick == 18)
            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        else
            send_beat(CH_EQUAL, 1'b1, 1'b0);
    endtask

    // one well-formed request with random content and a random closing
    task automatic send_query();
        int params;
        int p;
        int i;
        int len;
        params = $urandom_range(1, 4);
        for (p = 0; p < params; p++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            for (i = 0; i < len; i++)
                send_query_char();
            if ($urandom_range(0, 3) != 0)
            begin
                send_beat(CH_EQUAL, 1'b1, 1'b0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
                for (i = 0; i < len; i++)
                    send_query_char();
            end
            if (p < params - 1)
                send_beat(CH_AMP, 1'b1, 1'b0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_beat(8'("a" + $urandom_range(0, 25)), 1'b1, 1'b1);
            5, 6: send_beat(8'h00, 1'b0, 1'b1);
            7: send_beat(CH_AMP, 1'b1, 1'b1);
            8:
            begin
                send_beat(CH_PERCENT, 1'b1, 1'b0);
                if ($urandom_range(0, 1))
                    send_beat(rand_hex_char(), 1'b1, 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            default:
            begin
                send_beat(CH_AMP, 1'b1, 1'b0);
                send_beat(8'h00, 1'b0, 1'b1);
            end
        endcase
    endtask

    // raw beats with random flags, including empty beats that do nothing
    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 7) == 0);
    endtask

    task automatic run_random(input int quota, input bit vary_idle);
        int start;
        start = fed_items;
        while (fed_items - start < quota)
        begin
            if (vary_idle)
            begin
                feed_idle = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 19) < 17)
                send_query();
            else
                send_noise();
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset limits: separators, '+', escapes, '=' in value, specials in escapes
    task automatic test_directed();
        send_text("a=1&b+=%41=%zf", 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_text("%&=&", 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // incomplete escape, an empty beat, then an empty closing beat
        send_text("%4", 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_limit_extremes();
        set_limits(8'd0, 8'd255);
        send_text("ab=cd", 1'b1);
        set_limits(8'd255, 8'd0);
        send_text("ab=cd", 1'b1);
        set_limits(8'd1, 8'd1);
        send_text("abc=def&", 1'b1);
    endtask

    task automatic test_random_queries();
        int s;
        logic [7:0] nl;
        logic [7:0] vl;
        for (s = 0; s < 7; s++)
        begin
            case (s)
                0: begin nl = 8'd2;   vl = 8'd3;   end
                1: begin nl = 8'd0;   vl = 8'd0;   end
                2: begin nl = 8'd255; vl = 8'd255; end
                3: begin nl = 8'd1;   vl = 8'd0;   end
                4: begin nl = 8'd0;   vl = 8'd7;   end
                default:
                begin
                    nl = 8'($urandom_range(0, 12));
                    vl = 8'($urandom_range(0, 12));
                end
            endcase
            set_limits(nl, vl);
            run_random(110, 1'b1);
        end
        feed_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    // no gaps on either side, with one full drain in the middle
    task automatic test_back_to_back();
        set_limits(LIMIT_RESET, LIMIT_RESET);
        feed_idle = 1'b0;
        sink_idle = 1'b0;
        run_random(60, 1'b0);
        wait_drained();
        run_random(60, 1'b0);
        feed_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // result side: random stalls and checking
    // ---------------------------------------------------------------------

    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_results++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind %0d char %02h last %0b done %0b",
                             m_tuser[1:0], m_tdata, m_tlast, m_tuser[2]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[1:0] !== want.kind || m_tdata !== want.ch ||
                    m_tlast !== want.last || m_tuser[2] !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d kind %0d/%0d char %02h/%02h ",
                                  "last %0b/%0b done %0b/%0b (exp/got)"},
                                 seen_results, want.kind, m_tuser[1:0], want.ch, m_tdata,
                                 want.last, m_tlast, want.done, m_tuser[2]);
                end
            end
        end
    end

    // stop the run if no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
            $display("url_query_param_decoder test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        clear_param();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_limit_extremes();
        test_random_queries();
        test_back_to_back();
        wait_drained();
        $display("Summary: %0d query beats fed, %0d result beats checked, %0d limit writes",
                 fed_items, seen_results, limit_writes);
        $display({"Summary: escapes, plus, separators, limit drops and request ",
                  "closings, %0d errors"}, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("url_query_param_decoder test passed");
        else
            $display("url_query_param_decoder test failed");
        $finish;
    end

endmodule

### sim.f
rtl/uqpd_pkg.sv
rtl/uqpd_parse.sv
rtl/uqpd_res_fifo.sv
rtl/url_query_param_decoder.sv
tb/url_query_param_decoder_test.sv
